// ===== rtl/dc_motor_encoder_emulator_assert.svh =====
// assertion macros used by the checker file
`ifndef DC_MOTOR_ENCODER_EMULATOR_ASSERT_SVH
`define DC_MOTOR_ENCODER_EMULATOR_ASSERT_SVH

// antecedent now, consequent on the next edge
`define DCM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcm assertion failed");

// antecedent and consequent on the same edge
`define DCM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcm assertion failed");

`endif

// ===== rtl/dcm_pkg.sv =====
`timescale 1ns / 1ps
package dcm_pkg;

    localparam int STATE_FRAC_BITS_DEF = 16;
    localparam int COEFF_FRAC_BITS_DEF = 28;

    // multiplier digit size, coefficient bits consumed per cycle
    localparam int MUL_DIGIT = 8;
    localparam int MUL_STEPS = 32 / MUL_DIGIT;

    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 128;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [31:0] DRIVE_INCREMENT_RST = 32'd3221225;
    localparam logic [31:0] CURRENT_DECAY_RST   = 32'd536871;
    localparam logic [31:0] BACKEMF_COEFF_RST   = 32'd26844;
    localparam logic [31:0] TORQUE_COEFF_RST    = 32'd1342177;
    localparam logic [31:0] FRICTION_COEFF_RST  = 32'd26844;
    localparam logic [31:0] ENCODER_GAIN_RST    = 32'd4272285;
    localparam logic [31:0] RPM_GAIN_RST        = 32'd393216;
    localparam logic [15:0] INTERVAL_TICKS_RST  = 16'd100;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DRIVE_INCREMENT = 4'd0,
        REG_CURRENT_DECAY   = 4'd1,
        REG_BACKEMF_COEFF   = 4'd2,
        REG_TORQUE_COEFF    = 4'd3,
        REG_FRICTION_COEFF  = 4'd4,
        REG_ENCODER_GAIN    = 4'd5,
        REG_RPM_GAIN        = 4'd6,
        REG_INTERVAL_TICKS  = 4'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECAY,
        ST_BEMF,
        ST_TORQUE,
        ST_FRICTION,
        ST_ENCODER,
        ST_COUNT,
        ST_RPM,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic               go;
        logic [31:0]        coeff;
        logic signed [31:0] operand;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] product;
    } mul_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > 64'sh00007fffffffffff)
            r = 48'sh7fffffffffff;
        else if (v < -64'sh0000800000000000)
            r = 48'sh800000000000;
        else
            r = v[47:0];
        return r;
    endfunction

endpackage

// ===== rtl/dcm_mul.sv =====
`timescale 1ns / 1ps
module dcm_mul
(
    input  logic              clk,
    input  logic              rst_n,
    input  dcm_pkg::mul_req_t req,
    output dcm_pkg::mul_rsp_t rsp
);
    import dcm_pkg::*;

    localparam int CNT_W = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;
    localparam int HI_W  = 33;
    localparam int SUM_W = HI_W + MUL_DIGIT;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [31:0]             coeff_reg, coeff_next;
    logic signed [31:0]      opnd_reg, opnd_next;
    logic signed [HI_W-1:0]  hi_reg, hi_next;
    logic [31:0]             lo_reg, lo_next;

    logic signed [MUL_DIGIT:0] digit;
    logic signed [SUM_W-1:0]   part;
    logic signed [SUM_W-1:0]   sum;
    logic                      load;

    assign load  = req.go && !busy_reg && !done_reg;
    assign digit = {1'b0, coeff_reg[MUL_DIGIT-1:0]};
    assign part  = opnd_reg * digit;
    assign sum   = part + SUM_W'(hi_reg);

    // low digits leave the sum from the bottom and collect in lo
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        coeff_next = coeff_reg;
        opnd_next  = opnd_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            coeff_next = req.coeff;
            opnd_next  = req.operand;
            hi_next    = '0;
            lo_next    = '0;
        end
        else if (busy_reg)
        begin
            lo_next    = {sum[MUL_DIGIT-1:0], lo_reg[31:MUL_DIGIT]};
            hi_next    = HI_W'(sum >>> MUL_DIGIT);
            coeff_next = coeff_reg >> MUL_DIGIT;
            cnt_next   = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coeff_reg <= coeff_next;
        opnd_reg  <= opnd_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = {hi_reg[31:0], lo_reg};

endmodule

// ===== rtl/dc_motor_encoder_emulator.sv =====
`timescale 1ns / 1ps
// channel  dir  bits  contents
// s_axis   in   8     [0] tick_valid, rest unused
// m_axis   out  128   elapsed_ticks, shaft_speed, window_pulses, rpm_reading
// cfg      in   4+32  register index, write data
//
// a tick with tick_valid set runs the motor update, and also the rpm step when it reports
// five or six products per tick share one 32x8 multiplier, each 4 digit steps plus load and done
// a tick with tick_valid clear is taken while idle and changes nothing
// s_axis_tready is high only between ticks; a finished report waits in the output register
// reset restores the register defaults and clears the motor state
module dc_motor_encoder_emulator
#(
    parameter int STATE_FRAC_BITS = dcm_pkg::STATE_FRAC_BITS_DEF,
    parameter int COEFF_FRAC_BITS = dcm_pkg::COEFF_FRAC_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dcm_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // tick_valid
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // elapsed_ticks, shaft_speed, window_pulses, rpm_reading
    output logic [dcm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [dcm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dcm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dcm_pkg::*;

    localparam int ACC_W = (66 - COEFF_FRAC_BITS > 49) ? 66 - COEFF_FRAC_BITS : 49;
    localparam int DSH_R = (COEFF_FRAC_BITS >= STATE_FRAC_BITS) ?
                           COEFF_FRAC_BITS - STATE_FRAC_BITS : 0;
    localparam int DSH_L = (COEFF_FRAC_BITS >= STATE_FRAC_BITS) ?
                           0 : STATE_FRAC_BITS - COEFF_FRAC_BITS;
    localparam logic signed [48:0] ENC_BIAS = (49'sd1 <<< STATE_FRAC_BITS) - 49'sd1;

    // configuration
    logic [31:0] drive_reg, drive_next;
    logic [31:0] decay_reg, decay_next;
    logic [31:0] bemf_reg, bemf_next;
    logic [31:0] torque_reg, torque_next;
    logic [31:0] fric_reg, fric_next;
    logic [31:0] encg_reg, encg_next;
    logic [31:0] rpmg_reg, rpmg_next;
    logic [15:0] interval_reg, interval_next;

    // sequencer and motor state
    seq_state_t              state_reg, state_next;
    logic signed [31:0]      cur_reg, cur_next;
    logic signed [31:0]      spd_reg, spd_next;
    logic signed [31:0]      cur_new_reg, cur_new_next;
    logic signed [47:0]      enc_reg, enc_next;
    logic signed [31:0]      last_cnt_reg, last_cnt_next;
    logic [15:0]             phase_reg, phase_next;
    logic [31:0]             tick_reg, tick_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [31:0]      pulses_reg, pulses_next;
    logic signed [31:0]      rpm_reg, rpm_next;
    logic [31:0]             idx_reg, idx_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_idx_reg, out_idx_next;
    logic signed [31:0] out_spd_reg, out_spd_next;
    logic signed [31:0] out_pulses_reg, out_pulses_next;
    logic signed [31:0] out_rpm_reg, out_rpm_next;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    logic [63:0]             drive_wide;
    logic signed [ACC_W-1:0] acc_init;
    logic signed [ACC_W-1:0] scaled;
    logic signed [ACC_W-1:0] acc_add;
    logic signed [ACC_W-1:0] acc_sub;
    logic signed [48:0]      enc_round;
    logic signed [48:0]      count_wide;
    logic signed [31:0]      count_sat;
    logic signed [31:0]      pulses_sat;
    logic                    report;
    logic [15:0]             phase_inc;
    logic                    out_free;

    dcm_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign drive_wide = (64'(drive_reg) >> DSH_R) << DSH_L;
    assign acc_init   = ACC_W'(cur_reg) + $signed(ACC_W'(drive_wide));
    assign scaled     = ACC_W'(mul_rsp.product >>> COEFF_FRAC_BITS);
    assign acc_add    = acc_reg + scaled;
    assign acc_sub    = acc_reg - scaled;

    // truncate toward zero: bias negative positions before the shift
    assign enc_round  = 49'(enc_reg) + (enc_reg[47] ? ENC_BIAS : 49'sd0);
    assign count_wide = enc_round >>> STATE_FRAC_BITS;
    assign count_sat  = sat32(64'(count_wide));
    assign pulses_sat = sat32(64'(count_sat) - 64'(last_cnt_reg));

    assign report     = (phase_reg == 16'd0);
    assign phase_inc  = phase_reg + 16'd1;
    assign out_free   = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_rpm_reg, out_pulses_reg, out_spd_reg, out_idx_reg};

    // configuration writes
    always_comb
    begin
        drive_next    = drive_reg;
        decay_next    = decay_reg;
        bemf_next     = bemf_reg;
        torque_next   = torque_reg;
        fric_next     = fric_reg;
        encg_next     = encg_reg;
        rpmg_next     = rpmg_reg;
        interval_next = interval_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DRIVE_INCREMENT: drive_next    = cfg_data;
                REG_CURRENT_DECAY:   decay_next    = cfg_data;
                REG_BACKEMF_COEFF:   bemf_next     = cfg_data;
                REG_TORQUE_COEFF:    torque_next   = cfg_data;
                REG_FRICTION_COEFF:  fric_next     = cfg_data;
                REG_ENCODER_GAIN:    encg_next     = cfg_data;
                REG_RPM_GAIN:        rpmg_next     = cfg_data;
                REG_INTERVAL_TICKS:  interval_next = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid && s_axis_tdata[0])
                    state_next = ST_DECAY;
            ST_DECAY:
                if (mul_rsp.done)
                    state_next = ST_BEMF;
            ST_BEMF:
                if (mul_rsp.done)
                    state_next = ST_TORQUE;
            ST_TORQUE:
                if (mul_rsp.done)
                    state_next = ST_FRICTION;
            ST_FRICTION:
                if (mul_rsp.done)
                    state_next = ST_ENCODER;
            ST_ENCODER:
                if (mul_rsp.done)
                    state_next = ST_COUNT;
            ST_COUNT:
                state_next = report ? ST_RPM : ST_IDLE;
            ST_RPM:
                if (mul_rsp.done)
                    state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        cur_next        = cur_reg;
        spd_next        = spd_reg;
        cur_new_next    = cur_new_reg;
        enc_next        = enc_reg;
        last_cnt_next   = last_cnt_reg;
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        acc_next        = acc_reg;
        pulses_next     = pulses_reg;
        rpm_next        = rpm_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_idx_next    = out_idx_reg;
        out_spd_next    = out_spd_reg;
        out_pulses_next = out_pulses_reg;
        out_rpm_next    = out_rpm_reg;
        mul_req.go      = 1'b0;
        mul_req.coeff   = decay_reg;
        mul_req.operand = cur_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid && s_axis_tdata[0])
                    acc_next = acc_init;
            ST_DECAY:
            begin
                mul_req.go = 1'b1;
                if (mul_rsp.done)
                    acc_next = acc_sub;
            end
            ST_BEMF:
            begin
                mul_req.go      = 1'b1;
                mul_req.coeff   = bemf_reg;
                mul_req.operand = spd_reg;
                if (mul_rsp.done)
                begin
                    cur_new_next = sat32(64'(acc_sub));
                    acc_next     = ACC_W'(spd_reg);
                end
            end
            ST_TORQUE:
            begin
                mul_req.go    = 1'b1;
                mul_req.coeff = torque_reg;
                if (mul_rsp.done)
                    acc_next = acc_add;
            end
            ST_FRICTION:
            begin
                mul_req.go      = 1'b1;
                mul_req.coeff   = fric_reg;
                mul_req.operand = spd_reg;
                if (mul_rsp.done)
                begin
                    cur_next = cur_new_reg;
                    spd_next = sat32(64'(acc_sub));
                    acc_next = ACC_W'(enc_reg);
                end
            end
            ST_ENCODER:
            begin
                mul_req.go      = 1'b1;
                mul_req.coeff   = encg_reg;
                mul_req.operand = spd_reg;
                if (mul_rsp.done)
                    enc_next = sat48(64'(acc_add));
            end
            ST_COUNT:
            begin
                idx_next   = tick_reg;
                tick_next  = tick_reg + 32'd1;
                phase_next = (phase_inc >= interval_reg) ? 16'd0 : phase_inc;
                if (report)
                begin
                    pulses_next   = pulses_sat;
                    last_cnt_next = count_sat;
                end
            end
            ST_RPM:
            begin
                mul_req.go      = 1'b1;
                mul_req.coeff   = rpmg_reg;
                mul_req.operand = pulses_reg;
                if (mul_rsp.done)
                    rpm_next = sat32(mul_rsp.product);
            end
            ST_OUT:
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_idx_next    = idx_reg;
                    out_spd_next    = spd_reg;
                    out_pulses_next = pulses_reg;
                    out_rpm_next    = rpm_reg;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg     <= DRIVE_INCREMENT_RST;
            decay_reg     <= CURRENT_DECAY_RST;
            bemf_reg      <= BACKEMF_COEFF_RST;
            torque_reg    <= TORQUE_COEFF_RST;
            fric_reg      <= FRICTION_COEFF_RST;
            encg_reg      <= ENCODER_GAIN_RST;
            rpmg_reg      <= RPM_GAIN_RST;
            interval_reg  <= INTERVAL_TICKS_RST;
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            spd_reg       <= '0;
            enc_reg       <= '0;
            last_cnt_reg  <= '0;
            phase_reg     <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            drive_reg     <= drive_next;
            decay_reg     <= decay_next;
            bemf_reg      <= bemf_next;
            torque_reg    <= torque_next;
            fric_reg      <= fric_next;
            encg_reg      <= encg_next;
            rpmg_reg      <= rpmg_next;
            interval_reg  <= interval_next;
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            spd_reg       <= spd_next;
            enc_reg       <= enc_next;
            last_cnt_reg  <= last_cnt_next;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_new_reg    <= cur_new_next;
        acc_reg        <= acc_next;
        pulses_reg     <= pulses_next;
        rpm_reg        <= rpm_next;
        idx_reg        <= idx_next;
        out_idx_reg    <= out_idx_next;
        out_spd_reg    <= out_spd_next;
        out_pulses_reg <= out_pulses_next;
        out_rpm_reg    <= out_rpm_next;
    end

endmodule

// ===== rtl/dcm_checker.sv =====
`timescale 1ns / 1ps
`include "dc_motor_encoder_emulator_assert.svh"
module dcm_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [dcm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [dcm_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import dcm_pkg::*;

    // a stalled report holds
    `DCM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // a live tick keeps the block busy for the next cycle
    `DCM_ASSERT_NEXT(a_busy_after_tick, s_axis_tvalid && s_axis_tready && s_axis_tdata[0], !s_axis_tready)
    // a report never appears right after an item is taken
    `DCM_ASSERT_SAME(a_no_fast_report, $rose(m_axis_tvalid), !$past(s_axis_tvalid && s_axis_tready))
    // a new report is loaded only while the block is busy
    `DCM_ASSERT_SAME(a_report_from_busy, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind dc_motor_encoder_emulator dcm_checker u_dcm_checker (.*);
